>>> rtl/core/mexp_pkg.sv
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

    localparam int BASE_W = 64;
    localparam int EXP_IN_W = 64;
    localparam int OUT_W = 32;
    localparam int CNT_W = $clog2(BASE_W);

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    localparam logic [0:0] REG_MODULUS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_MUL_ACC,
        ST_MUL_SQR,
        ST_FINISH
    } mexp_state_t;

endpackage

>>> rtl/core/mexp_in_if.sv
// Request channel carrying base and exponent.
interface mexp_in_if;
    import mexp_pkg::*;

    logic                valid;
    logic                ready;
    logic [BASE_W-1:0]   base_value;
    logic [EXP_IN_W-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink (input valid, input base_value, input exponent, output ready);
endinterface

>>> rtl/core/mexp_out_if.sv
// Result channel carrying the modular power.
interface mexp_out_if;
    import mexp_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink (input valid, input power_result, output ready);
endinterface

>>> rtl/core/mexp_modadd.sv
// Modular adder: (x + y + carry_in) mod m for a sum below twice the modulus.
module mexp_modadd #(
    parameter int W = 32
) (
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic         carry_in,
    input  logic [W-1:0] m,
    output logic [W-1:0] sum
);

    logic [W:0] total;
    logic [W:0] diff;
    logic       ge;

    assign total = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, carry_in};
    assign ge    = (total >= {1'b0, m});
    assign diff  = total - {1'b0, m};
    assign sum   = ge ? diff[W-1:0] : total[W-1:0];

endmodule

>>> rtl/core/mexp_cfg.sv
// APB register block holding the modulus.
module mexp_cfg #(
    parameter int MOD_WIDTH = 32,
    parameter int DATA_W    = 32,
    parameter int ADDR_LSB  = 2,
    parameter int ADDR_W    = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    output logic [MOD_WIDTH-1:0] modulus
);
    import mexp_pkg::*;

    localparam logic [MOD_WIDTH-1:0] RESET_TRUNC = MODULUS_RESET[MOD_WIDTH-1:0];
    localparam logic [MOD_WIDTH-1:0] RESET_VALUE =
        (RESET_TRUNC == '0) ? MOD_WIDTH'(1) : RESET_TRUNC;

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic [MOD_WIDTH-1:0] modulus_next;
    logic [0:0]           reg_index;
    logic                 wr_en;

    assign reg_index = paddr[ADDR_W-1:ADDR_LSB];
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_MODULUS)
                       && (pwdata[MOD_WIDTH-1:0] != '0);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_en)
        begin
            modulus_next = pwdata[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= RESET_VALUE;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata  = (reg_index == REG_MODULUS) ? DATA_W'(modulus_reg) : '0;
    assign pready  = 1'b1;
    assign modulus = modulus_reg;

endmodule

>>> rtl/core/mexp_engine.sv
// Square-and-multiply sequencer around two modular adder lanes.
module mexp_engine #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MOD_WIDTH-1:0] modulus,
    mexp_in_if.sink              in_ch,
    mexp_out_if.source           out_ch
);
    import mexp_pkg::*;

    mexp_state_t state_reg, state_next;

    logic [BASE_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0] power_reg, power_next;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [MOD_WIDTH-1:0] mx_reg, mx_next;
    logic [MOD_WIDTH-1:0] my_reg, my_next;
    logic [MOD_WIDTH-1:0] mp_reg, mp_next;
    logic [OUT_W-1:0]     res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;

    logic [MOD_WIDTH-1:0] a_x, a_y, a_sum, b_sum;
    logic                 a_c;
    logic                 accept;
    logic                 load_out;

    mexp_modadd #(.W(MOD_WIDTH)) u_lane_a (
        .x        (a_x),
        .y        (a_y),
        .carry_in (a_c),
        .m        (modulus),
        .sum      (a_sum)
    );

    mexp_modadd #(.W(MOD_WIDTH)) u_lane_b (
        .x        (mx_reg),
        .y        (mx_reg),
        .carry_in (1'b0),
        .m        (modulus),
        .sum      (b_sum)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (state_reg == ST_REDUCE)
        begin
            a_x = power_reg;
            a_y = power_reg;
            a_c = base_reg[BASE_W-1];
        end
        else
        begin
            a_x = mp_reg;
            a_y = mx_reg;
            a_c = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        power_next = power_reg;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mp_next    = mp_reg;
        res_next   = res_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next  = in_ch.base_value;
                    exp_next   = in_ch.exponent[EXP_WIDTH-1:0];
                    power_next = '0;
                    cnt_next   = '1;
                    acc_next   = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                power_next = a_sum;
                base_next  = {base_reg[BASE_W-2:0], 1'b0};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mp_next = '0;
                my_next = power_reg;
                if (exp_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mx_next    = acc_reg;
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    mx_next    = power_reg;
                    state_next = ST_MUL_SQR;
                end
            end
            ST_MUL_ACC, ST_MUL_SQR:
            begin
                if (my_reg == '0)
                begin
                    if (state_reg == ST_MUL_ACC)
                    begin
                        acc_next   = mp_reg;
                        mx_next    = power_reg;
                        my_next    = power_reg;
                        mp_next    = '0;
                        state_next = ST_MUL_SQR;
                    end
                    else
                    begin
                        power_next = mp_reg;
                        exp_next   = exp_reg >> 1;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    if (my_reg[0])
                    begin
                        mp_next = a_sum;
                    end
                    mx_next = b_sum;
                    my_next = my_reg >> 1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    res_next   = OUT_W'(acc_reg);
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        cnt_reg   <= cnt_next;
        power_reg <= power_next;
        acc_reg   <= acc_next;
        exp_reg   <= exp_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        mp_reg    <= mp_next;
        res_reg   <= res_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.power_result = res_reg;

endmodule

>>> rtl/core/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: register block and engine.
//
//  port group   role     contents
//  in_ch        sink     base_value[63:0], exponent[63:0]
//  out_ch       source   power_result[31:0]
//  apb          slave    modulus at offset 0
//
// A request yields its result and frees in_ch after these steps: the base is reduced bit by bit,
// then for each exponent bit up to the highest set bit the engine scans the bit, multiplies the
// accumulator by the power if the bit is set and squares the power, each product built by
// shift-and-add over the bits of the current power; a last scan passes the final bit and loads the result.
// Reset clears the sequencer and the output valid; the modulus returns to 1e9+7.
// in_ch is ready only while the engine is idle; a result held by a stalled out_ch lets the next
// request in, and that request then waits with its own result until out_ch takes the first.
module modular_exponentiation_unit #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 64,
    localparam int DATA_W   = (MOD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB = (MOD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W   = ADDR_LSB + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    mexp_in_if.sink           in_ch,
    mexp_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    import mexp_pkg::*;

    logic [MOD_WIDTH-1:0] modulus;

    mexp_cfg #(
        .MOD_WIDTH (MOD_WIDTH),
        .DATA_W    (DATA_W),
        .ADDR_LSB  (ADDR_LSB),
        .ADDR_W    (ADDR_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    mexp_engine #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    a_modulus_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        modulus != '0)
        else $error("modulus register holds zero");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (64'(out_ch.power_result) < 64'(modulus)))
        else $error("result not reduced below modulus");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request taken while engine busy");

endmodule
